// ===== sv/cfb_pkg.sv =====
`default_nettype none

package cfb_pkg;

  // Default frame geometry
  localparam int DEF_PREAMBLE_COUNT = 11;
  localparam int DEF_ADDRESS_BYTES  = 8;

  // Counter wide enough for the longest preamble or address run
  localparam int CNT_W = 5;

  // Fixed frame bytes and CRC seed
  localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
  localparam logic [7:0]  FLAG_BYTE     = 8'h00;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  // Configuration register reset values
  localparam logic [7:0]  HEADER_RESET    = 8'hA5;
  localparam logic [7:0]  TYPE_RESET      = 8'h03;
  localparam logic [15:0] TIMESTAMP_RESET = 16'hFFFF;

  // Configuration register indexes (word address)
  localparam int         REG_IDX_W     = 2;
  localparam logic [1:0] REG_HEADER    = 2'd0;
  localparam logic [1:0] REG_TYPE      = 2'd1;
  localparam logic [1:0] REG_TIMESTAMP = 2'd2;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  frame_type;
    logic [15:0] timestamp_word;
  } cfg_t;

  // Byte handed to the CRC unit
  typedef struct packed {
    logic       init;
    logic       en;
    logic [7:0] data;
  } crc_ctl_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    logic load_last;
  } seq_stat_t;

  // Fold one byte into a CRC-16 (poly 0x1021, MSB first)
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = {c[7:0], c[15:8]};
    v = v ^ {8'h00, b};
    v = v ^ {12'h000, v[7:4]};
    v = v ^ {v[3:0], 12'h000};
    v = v ^ {3'b000, v[7:0], 5'b00000};
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cfb_crc.sv =====
`default_nettype none

module cfb_crc
  import cfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crc_ctl_t    ctl,
  output logic [15:0]      crc
);

  // Seed on a new frame, fold one byte per cycle while enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.en) begin
      crc <= crc_byte(crc, ctl.data);
    end
  end

endmodule

`default_nettype wire

// ===== sv/cfb_seq.sv =====
`default_nettype none

module cfb_seq
  import cfb_pkg::*;
#(
  parameter int PREAMBLE_COUNT = DEF_PREAMBLE_COUNT,
  parameter int ADDRESS_BYTES  = DEF_ADDRESS_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  // request: [63:0] node_address, [71:64] command
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // frame byte: [7:0] out_byte
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output crc_ctl_t         crc_ctl,
  input  wire logic [15:0] crc,
  output seq_stat_t        stat
);

  localparam int ADDR_W = 8 * ADDRESS_BYTES;
  localparam logic [7:0] LEN_BYTE = 8'(ADDRESS_BYTES + 1);
  localparam logic [CNT_W-1:0] PRE_END  = CNT_W'(PREAMBLE_COUNT - 1);
  localparam logic [CNT_W-1:0] ADDR_END = CNT_W'(ADDRESS_BYTES - 1);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_PRE  = 12'b000000000010,
    ST_HDR  = 12'b000000000100,
    ST_TSH  = 12'b000000001000,
    ST_TSL  = 12'b000000010000,
    ST_TYPE = 12'b000000100000,
    ST_LEN  = 12'b000001000000,
    ST_ADDR = 12'b000010000000,
    ST_CMD  = 12'b000100000000,
    ST_FLAG = 12'b001000000000,
    ST_CRCH = 12'b010000000000,
    ST_CRCL = 12'b100000000000
  } state_t;

  localparam state_t FIRST_ST = (PREAMBLE_COUNT == 0) ? ST_HDR : ST_PRE;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [ADDR_W-1:0]  addr_sr;
  logic [7:0]         held_command;
  logic [7:0]         byte_sel;
  logic               crc_on;
  logic               last_sel;
  logic               advance;
  logic               accept;
  logic               emit;

  // Output register frees up when empty or when its byte is taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) || ((state == ST_CRCL) && advance);
  assign accept   = s_tvalid && s_tready;
  assign emit     = (state != ST_IDLE) && advance;

  // Pick the byte of the current phase and the phase after it
  always_comb begin
    byte_sel   = PREAMBLE_BYTE;
    crc_on     = 1'b0;
    last_sel   = 1'b0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = FIRST_ST;
          cnt_next   = '0;
        end
      end
      ST_PRE: begin
        if (cnt == PRE_END) begin
          state_next = ST_HDR;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_HDR: begin
        byte_sel   = cfg.header_byte;
        crc_on     = 1'b1;
        state_next = ST_TSH;
      end
      ST_TSH: begin
        byte_sel   = cfg.timestamp_word[15:8];
        crc_on     = 1'b1;
        state_next = ST_TSL;
      end
      ST_TSL: begin
        byte_sel   = cfg.timestamp_word[7:0];
        crc_on     = 1'b1;
        state_next = ST_TYPE;
      end
      ST_TYPE: begin
        byte_sel   = cfg.frame_type;
        crc_on     = 1'b1;
        state_next = ST_LEN;
      end
      ST_LEN: begin
        byte_sel   = LEN_BYTE;
        crc_on     = 1'b1;
        state_next = ST_ADDR;
        cnt_next   = '0;
      end
      ST_ADDR: begin
        byte_sel = addr_sr[7:0];
        crc_on   = 1'b1;
        if (cnt == ADDR_END) begin
          state_next = ST_CMD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CMD: begin
        byte_sel   = held_command;
        crc_on     = 1'b1;
        state_next = ST_FLAG;
      end
      ST_FLAG: begin
        byte_sel   = FLAG_BYTE;
        crc_on     = 1'b1;
        state_next = ST_CRCH;
      end
      ST_CRCH: begin
        byte_sel   = crc[15:8];
        state_next = ST_CRCL;
      end
      ST_CRCL: begin
        byte_sel = crc[7:0];
        last_sel = 1'b1;
        if (accept) begin
          state_next = FIRST_ST;
          cnt_next   = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Advance the phase when a request is accepted or a byte moves into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else if (accept || emit) begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Hold the request; shift the address out one byte per cycle while bytes are emitted
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_sr      <= s_tdata[ADDR_W-1:0];
      held_command <= s_tdata[71:64];
    end else if (emit && (state == ST_ADDR)) begin
      addr_sr <= addr_sr >> 8;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_sel;
      m_tlast <= last_sel;
    end
  end

  assign crc_ctl.init = accept;
  assign crc_ctl.en   = emit && crc_on;
  assign crc_ctl.data = byte_sel;

  assign stat.busy      = (state != ST_IDLE);
  assign stat.load_last = emit && last_sel;

endmodule

`default_nettype wire

// ===== sv/command_frame_builder_crc16_core.sv =====
// After a request is accepted the sequencer leaves idle, then loads the first byte.
// Frame bytes go out one per cycle while m_tready allows; a frame is PREAMBLE_COUNT +
// ADDRESS_BYTES + 9 bytes (28 by default), and a new request is taken as the last CRC
// byte loads; the byte-serial sequencer and one-byte-per-cycle CRC set the rate.
// Reset: registers return to header 0xA5, type 0x03, timestamp 0xFFFF; the
// sequencer goes idle, the output register empties and the CRC reseeds to 0xFFFF.
`default_nettype none

module command_frame_builder_crc16_core
  import cfb_pkg::*;
#(
  parameter int PREAMBLE_COUNT = DEF_PREAMBLE_COUNT,
  parameter int ADDRESS_BYTES  = DEF_ADDRESS_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request: [63:0] node_address, [71:64] command
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // frame byte: [7:0] out_byte; tlast = last_byte
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready
);

  cfg_t                 cfg;
  crc_ctl_t             crc_ctl;
  seq_stat_t            stat;
  logic [15:0]          crc;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte    <= HEADER_RESET;
      cfg.frame_type     <= TYPE_RESET;
      cfg.timestamp_word <= TIMESTAMP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEADER:    cfg.header_byte    <= pwdata[7:0];
        REG_TYPE:      cfg.frame_type     <= pwdata[7:0];
        REG_TIMESTAMP: cfg.timestamp_word <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_HEADER:    prdata = {24'h000000, cfg.header_byte};
      REG_TYPE:      prdata = {24'h000000, cfg.frame_type};
      REG_TIMESTAMP: prdata = {16'h0000, cfg.timestamp_word};
      default:       prdata = 32'h00000000;
    endcase
  end

  cfb_seq #(
    .PREAMBLE_COUNT(PREAMBLE_COUNT),
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .crc_ctl (crc_ctl),
    .crc     (crc),
    .stat    (stat)
  );

  cfb_crc u_crc (
    .clk(clk),
    .rst(rst),
    .ctl(crc_ctl),
    .crc(crc)
  );

  // The CRC low byte lands in the output register flagged as last
  a_last_loaded: assert property (@(posedge clk) disable iff (rst)
    stat.load_last |=> (m_tvalid && m_tlast))
    else $error("last byte not presented after load");

  // A new request reseeds the CRC
  a_crc_seed: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (crc == CRC_INIT))
    else $error("CRC not reseeded on new request");

  // With the sequencer idle only the final byte of a frame can be pending
  a_idle_tail: assert property (@(posedge clk) disable iff (rst)
    !stat.busy |-> (!m_tvalid || m_tlast))
    else $error("non-final byte pending while idle");

endmodule

`default_nettype wire

// ===== dv/command_frame_builder_crc16_core_tb.sv =====
`default_nettype none

module command_frame_builder_crc16_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int FRAME_LEN     = DEF_PREAMBLE_COUNT + DEF_ADDRESS_BYTES + 9;
  localparam int IDLE_PCT      = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 62;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One request as it sits on s_tdata
  typedef struct packed {
    logic [7:0]  command;
    logic [63:0] node_address;
  } request_t;

  // One frame byte the block owes us
  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [71:0] s_tdata  = '0;   // [63:0] node_address, [71:64] command
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  // Shadow copy of the configuration registers
  logic [7:0]  header_cfg = HEADER_RESET;
  logic [7:0]  type_cfg   = TYPE_RESET;
  logic [15:0] stamp_cfg  = TIMESTAMP_RESET;

  request_t    pending_requests[$];
  frame_byte_t frame_bytes_due[$];

  bit          steady    = 1'b0;
  bit          req_taken = 1'b0;
  int unsigned requests_sent, bytes_checked, error_count, cycle_count, settings_used;

  always #5 clk = ~clk;

  command_frame_builder_crc16_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // Bitwise CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  // Queue every byte of the frame a request should produce
  task automatic predict_frame(request_t req);
    logic [7:0]  body[$];
    logic [15:0] crc;
    body.push_back(header_cfg);
    body.push_back(stamp_cfg[15:8]);
    body.push_back(stamp_cfg[7:0]);
    body.push_back(type_cfg);
    body.push_back(8'(DEF_ADDRESS_BYTES + 1));
    for (int i = 0; i < DEF_ADDRESS_BYTES; i++) begin
      body.push_back(req.node_address[8*i +: 8]);
    end
    body.push_back(req.command);
    body.push_back(FLAG_BYTE);
    crc = CRC_INIT;
    for (int i = 0; i < DEF_PREAMBLE_COUNT; i++) begin
      frame_bytes_due.push_back('{PREAMBLE_BYTE, 1'b0});
    end
    foreach (body[i]) begin
      crc = crc16_fold(crc, body[i]);
      frame_bytes_due.push_back('{body[i], 1'b0});
    end
    frame_bytes_due.push_back('{crc[15:8], 1'b0});
    frame_bytes_due.push_back('{crc[7:0], 1'b1});
  endtask

  function automatic request_t random_request();
    request_t r;
    case ($urandom_range(7))
      0: r.node_address = '0;
      1: r.node_address = '1;
      default: r.node_address = {$urandom, $urandom};
    endcase
    r.command = 8'($urandom);
    return r;
  endfunction

  // Count cycles, predict on accepted requests, check accepted bytes
  always @(posedge clk) begin
    frame_byte_t due;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, frame_bytes_due.size());
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      req_taken = s_tvalid && s_tready;
      if (req_taken) begin
        predict_frame(s_tdata);
        requests_sent++;
      end
      if (m_tvalid && m_tready) begin
        if (frame_bytes_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte, expected none, got %02h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          due = frame_bytes_due.pop_front();
          bytes_checked++;
          if (m_tdata !== due.value) begin
            error_count++;
            $display("%0t: out_byte expected %02h got %02h", $time, due.value, m_tdata);
          end
          if (m_tlast !== due.last) begin
            error_count++;
            $display("%0t: last_byte expected %0b got %0b", $time, due.last, m_tlast);
          end
        end
      end
    end
  end

  // Drive requests and back-pressure at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (!s_tvalid || req_taken) begin
        if (pending_requests.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_tdata  <= pending_requests.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Setup cycle, access cycle, then release the bus
  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HEADER:    header_cfg = data[7:0];
      REG_TYPE:      type_cfg   = data[7:0];
      REG_TIMESTAMP: stamp_cfg  = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write all registers with junk in the unused upper bits, plus the unmapped slot
  task automatic apply_setting(logic [7:0] hdr, logic [7:0] ftype, logic [15:0] stamp);
    reg_write(REG_HEADER, {24'($urandom), hdr});
    reg_write(REG_TYPE, {24'($urandom), ftype});
    reg_write(REG_TIMESTAMP, {16'($urandom), stamp});
    reg_write(REG_UNUSED, $urandom);
    settings_used++;
  endtask

  // Hold until every request is taken and every frame byte has arrived
  task automatic finish_phase();
    do begin
      @(negedge clk);
      #1;
    end while (pending_requests.size() != 0 || s_tvalid || frame_bytes_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_requests.push_back(random_request());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration, field extremes, sent back to back
    steady = 1'b1;
    settings_used = 1;
    pending_requests.push_back('{8'h00, 64'h0000_0000_0000_0000});
    pending_requests.push_back('{8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_requests.push_back('{8'h5A, 64'h0807_0605_0403_0201});
    pending_requests.push_back('{8'h55, 64'hAAAA_AAAA_AAAA_AAAA});
    pending_requests.push_back('{8'hAA, 64'h5555_5555_5555_5555});
    pending_requests.push_back('{8'h80, 64'h8000_0000_0000_0001});
    pending_requests.push_back('{8'h01, 64'h0000_0000_0000_00FF});
    pending_requests.push_back('{8'h7F, 64'hFF00_0000_0000_0000});
    finish_phase();

    // Register extremes with random traffic
    steady = 1'b0;
    apply_setting(8'h00, 8'h00, 16'h0000);
    queue_random(PHASE_ITEMS);
    finish_phase();

    apply_setting(8'hFF, 8'hFF, 16'hFFFF);
    steady = 1'b1;
    queue_random(PHASE_ITEMS);
    finish_phase();
    steady = 1'b0;

    // Random settings
    repeat (4) begin
      apply_setting(8'($urandom), 8'($urandom), 16'($urandom));
      queue_random(PHASE_ITEMS);
      finish_phase();
    end

    repeat (FRAME_LEN) @(negedge clk);
    $display("Checked %0d frames (%0d bytes) across %0d register settings,",
             requests_sent, bytes_checked, settings_used);
    $display("including back-to-back frames, extreme fields and unmapped writes.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
